### rtl/keypad_press_classifier_unit_defines.svh
// Assertion macros used by the keypad press classifier unit.
`ifndef KEYPAD_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`define KEYPAD_PRESS_CLASSIFIER_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
`define KPC_ASSERT(lbl, ck, rn, prop) \
	lbl: assert property (@(posedge ck) disable iff (!rn) prop) \
		else $error("keypad classifier property failed");
`define KPC_ASSERT_NEVER(lbl, ck, rn, cond) \
	lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
		else $error("keypad classifier forbidden condition seen");
`else
`define KPC_ASSERT(lbl, ck, rn, prop)
`define KPC_ASSERT_NEVER(lbl, ck, rn, cond)
`endif
`endif

### rtl/kpc_pkg.sv
package kpc_pkg;

	localparam int COUNTER_WIDTH = 16;
	localparam int NUM_SLOTS     = 23;
	localparam int THRESH_W      = 16;
	localparam int LED_W         = 21;
	localparam int LED_IDX_W     = $clog2(LED_W);
	localparam int SENSOR_W      = 24;
	localparam int SENSOR_IDX_W  = $clog2(SENSOR_W);
	localparam int CODE_W        = 5;
	localparam int IN_TDATA_W    = 32;
	localparam int OUT_TDATA_W   = 32;
	localparam int OUT_FIELDS_W  = CODE_W + LED_W + 1;
	localparam int CFG_ADDR_W    = 3;
	localparam int CFG_DATA_W    = 21;

	typedef logic [CODE_W-1:0] event_code_t;

	localparam event_code_t EV_NONE = 5'd25;

	typedef enum logic [2:0] {
		KIND_PLAIN  = 3'd0,
		KIND_SECRET = 3'd1,
		KIND_MENU   = 3'd2,
		KIND_ENTER  = 3'd3,
		KIND_PUNCH  = 3'd4,
		KIND_COMBO  = 3'd5
	} slot_kind_t;

	typedef enum logic [CFG_ADDR_W-1:0] {
		CFG_SHORT_TICKS = 3'd0,
		CFG_LONG_TICKS  = 3'd1,
		CFG_KEY_MASK    = 3'd2,
		CFG_LED_HOLD    = 3'd3,
		CFG_PUNCH_BLOCK = 3'd4,
		CFG_KEYS_OFF    = 3'd5
	} cfg_index_t;

	localparam logic [THRESH_W-1:0] SHORT_TICKS_RESET = 16'd3;
	localparam logic [THRESH_W-1:0] LONG_TICKS_RESET  = 16'd300;

	typedef struct packed {
		logic        valid;
		logic        last;
		event_code_t code;
	} token_t;

	// The sensor bytes are viewed as one 24-bit word: bank 0 low, bank 2 high.
	localparam int COMBO_SLOT = 5;
	localparam logic [SENSOR_IDX_W-1:0] SENSOR_AA = 5'd16;
	localparam logic [SENSOR_IDX_W-1:0] SENSOR_AB = 5'd21;
	localparam logic [LED_IDX_W-1:0]    NO_LED    = '1;

	// Slots in scan order; the AA+AB combo counter sits right after AB.
	localparam logic [SENSOR_IDX_W-1:0] SLOT_SENSOR [NUM_SLOTS] = '{
		5'd19, 5'd20, 5'd16, 5'd18, 5'd21, 5'd0, 5'd17, 5'd22, 5'd8, 5'd9,
		5'd23, 5'd15, 5'd13, 5'd10, 5'd0, 5'd2, 5'd5, 5'd14, 5'd12, 5'd11,
		5'd1, 5'd3, 5'd4
	};

	localparam logic [LED_IDX_W-1:0] SLOT_LED [NUM_SLOTS] = '{
		5'd2, 5'd3, 5'd0, NO_LED, 5'd1, NO_LED, 5'd4, 5'd5, 5'd6, 5'd7,
		5'd8, 5'd9, 5'd11, 5'd10, 5'd12, 5'd15, 5'd18, 5'd13, 5'd16, 5'd19,
		5'd14, 5'd17, 5'd20
	};

	localparam slot_kind_t SLOT_KIND [NUM_SLOTS] = '{
		KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_SECRET, KIND_PLAIN, KIND_COMBO,
		KIND_MENU, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PUNCH, KIND_PLAIN,
		KIND_PLAIN, KIND_ENTER, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN,
		KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN
	};

	localparam event_code_t SLOT_SHORT [NUM_SLOTS] = '{
		5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5, 5'd7, 5'd8, 5'd9, 5'd10,
		5'd11, 5'd12, 5'd13, 5'd15, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21,
		5'd22, 5'd23, 5'd24
	};

	localparam event_code_t SLOT_LONG [NUM_SLOTS] = '{
		5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd6, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0, 5'd14, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0, 5'd0,
		5'd0, 5'd0, 5'd0
	};

endpackage

### rtl/keypad_press_classifier_unit.sv
// Keypad short/long press classifier. Each input transaction is one scan tick
// (three sensor bytes and the door bit); it yields one output transaction per
// key event in scan order, or a single "no event" code, with tlast on the final
// one. The tick is evaluated by a row of 23 counter cells, which then hand their
// event tokens down the row toward the output register, one cell per cycle while
// a cell below or the output register has room. The next tick is evaluated only
// once the row has emptied; a one-entry input stage takes the next tick meanwhile.
// Configuration writes are meant for idle periods only.
`include "keypad_press_classifier_unit_defines.svh"
module keypad_press_classifier_unit #(
	parameter int COUNTER_WIDTH = kpc_pkg::COUNTER_WIDTH
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [kpc_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [kpc_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sensor_bank_zero[7:0], sensor_bank_one[15:8], sensor_bank_two[23:16],
	// door_shut[24], zero fill above
	input  logic [kpc_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// event_code[4:0], led_mask[25:5], some_key_pressed[26], zero fill above
	output logic [kpc_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);
	import kpc_pkg::*;

	logic [THRESH_W-1:0]  short_ticks_q;
	logic [THRESH_W-1:0]  long_ticks_q;
	logic [LED_W-1:0]     key_mask_q;
	logic                 led_hold_q;
	logic                 punch_block_q;
	logic                 keys_off_q;

	logic                 pend_valid_q;
	logic [SENSOR_W-1:0]  pend_sensor_q;
	logic                 pend_door_q;

	logic [LED_W-1:0]     led_q;
	logic [LED_W-1:0]     led_n;
	logic                 flag_q;

	logic                 load;
	logic                 out_free;
	logic                 move_out;

	logic [NUM_SLOTS-1:0] pressed;
	logic [NUM_SLOTS-1:0] enabled;
	logic [NUM_SLOTS-1:0] ev_valid;
	logic [NUM_SLOTS-1:0] ev_last;
	logic [NUM_SLOTS-1:0] advance;
	logic [NUM_SLOTS-1:0] tok_valid;
	logic [NUM_SLOTS-1:0] tok_last;
	token_t               tok [NUM_SLOTS];

	logic                 m_tvalid_q;
	event_code_t          out_code_q;
	logic                 out_last_q;
	logic [LED_W-1:0]     out_led_q;
	logic                 out_flag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_ticks_q <= SHORT_TICKS_RESET;
			long_ticks_q  <= LONG_TICKS_RESET;
			key_mask_q    <= '1;
			led_hold_q    <= 1'b0;
			punch_block_q <= 1'b0;
			keys_off_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index_t'(cfg_addr))
				CFG_SHORT_TICKS: short_ticks_q <= cfg_wdata[THRESH_W-1:0];
				CFG_LONG_TICKS:  long_ticks_q  <= cfg_wdata[THRESH_W-1:0];
				CFG_KEY_MASK:    key_mask_q    <= cfg_wdata[LED_W-1:0];
				CFG_LED_HOLD:    led_hold_q    <= cfg_wdata[0];
				CFG_PUNCH_BLOCK: punch_block_q <= cfg_wdata[0];
				CFG_KEYS_OFF:    keys_off_q    <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// A held tick is evaluated once every token of the previous tick has left the row.
	assign load     = pend_valid_q && !(|tok_valid);
	assign s_tready = !pend_valid_q || load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
		end else if (s_tready) begin
			pend_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			pend_sensor_q <= s_tdata[SENSOR_W-1:0];
			pend_door_q   <= s_tdata[SENSOR_W];
		end
	end

	always_comb begin
		for (int s = 0; s < NUM_SLOTS; s++) begin
			if (s == COMBO_SLOT) begin
				pressed[s] = pend_sensor_q[SENSOR_AA] && pend_sensor_q[SENSOR_AB];
			end else begin
				pressed[s] = pend_sensor_q[SLOT_SENSOR[s]];
			end
			enabled[s] = (SLOT_LED[s] == NO_LED) ? 1'b1 : key_mask_q[SLOT_LED[s]];
		end
	end

	always_comb begin
		led_n = led_q;
		if (!led_hold_q) begin
			for (int s = 0; s < NUM_SLOTS; s++) begin
				if (SLOT_LED[s] != NO_LED) begin
					if (pressed[s]) begin
						led_n[SLOT_LED[s]] = 1'b1;
					end else if (!(SLOT_KIND[s] == KIND_PUNCH && punch_block_q)) begin
						led_n[SLOT_LED[s]] = 1'b0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_q  <= '0;
			flag_q <= 1'b0;
		end else if (load) begin
			if (keys_off_q) begin
				flag_q <= flag_q || pend_door_q;
			end else begin
				led_q <= led_n;
			end
		end
	end

	assign out_free = !m_tvalid_q || m_tready;
	assign move_out = tok_valid[0] && out_free;

	for (genvar g = 0; g < NUM_SLOTS; g++) begin : g_cell
		token_t up_tok;
		logic   ld_none;

		// A cell refills whenever some cell at or below it has room, or the output register can take a token.
		assign advance[g] = out_free || !(&tok_valid[g:0]);

		if (g == NUM_SLOTS - 1) begin : g_tail
			assign up_tok      = '0;
			assign ld_none     = !(|ev_valid);
			assign ev_last[g]  = ev_valid[g];
		end else begin : g_body
			assign up_tok      = tok[g+1];
			assign ld_none     = 1'b0;
			assign ev_last[g]  = ev_valid[g] && !(|ev_valid[NUM_SLOTS-1:g+1]);
		end

		kpc_cell #(
			.CounterWidth (COUNTER_WIDTH)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.active      (!keys_off_q),
			.load        (load),
			.ld_none     (ld_none),
			.ld_last     (ev_last[g]),
			.advance     (advance[g]),
			.pressed     (pressed[g]),
			.enabled     (enabled[g]),
			.kind        (SLOT_KIND[g]),
			.short_code  (SLOT_SHORT[g]),
			.long_code   (SLOT_LONG[g]),
			.short_ticks (short_ticks_q),
			.long_ticks  (long_ticks_q),
			.up_tok      (up_tok),
			.ev_valid    (ev_valid[g]),
			.tok         (tok[g])
		);

		assign tok_valid[g] = tok[g].valid;
		assign tok_last[g]  = tok[g].last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_free) begin
			m_tvalid_q <= tok_valid[0];
		end
	end

	always_ff @(posedge clk) begin
		if (move_out) begin
			out_code_q <= tok[0].code;
			out_last_q <= tok[0].last;
			out_led_q  <= led_q;
			out_flag_q <= flag_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tlast  = out_last_q;
	assign m_tdata  = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_flag_q, out_led_q, out_code_q};

	`KPC_ASSERT(a_load_fills_row, clk, arst_n, load |=> (|tok_valid))
	`KPC_ASSERT_NEVER(a_single_last, clk, arst_n, $countones(tok_valid & tok_last) > 1)
	`KPC_ASSERT(a_led_frozen, clk, arst_n, $past(led_hold_q) |-> $stable(led_q))
	`KPC_ASSERT(a_stall_when_busy, clk, arst_n, (pend_valid_q && (|tok_valid)) |-> !s_tready)

endmodule

### rtl/kpc_cell.sv
module kpc_cell #(
	parameter int CounterWidth = kpc_pkg::COUNTER_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          active,
	input  logic                          load,
	input  logic                          ld_none,
	input  logic                          ld_last,
	input  logic                          advance,
	input  logic                          pressed,
	input  logic                          enabled,
	input  kpc_pkg::slot_kind_t           kind,
	input  kpc_pkg::event_code_t          short_code,
	input  kpc_pkg::event_code_t          long_code,
	input  logic [kpc_pkg::THRESH_W-1:0]  short_ticks,
	input  logic [kpc_pkg::THRESH_W-1:0]  long_ticks,
	input  kpc_pkg::token_t               up_tok,
	output logic                          ev_valid,
	output kpc_pkg::token_t               tok
);
	import kpc_pkg::*;

	localparam int CmpW = (CounterWidth > THRESH_W) ? CounterWidth : THRESH_W;

	logic [CounterWidth-1:0] cnt_q;
	logic [CounterWidth-1:0] cnt_bumped;
	logic [CounterWidth-1:0] cnt_press;
	logic [CmpW-1:0]         old_x;
	logic [CmpW-1:0]         new_x;
	logic [CmpW-1:0]         short_x;
	logic [CmpW-1:0]         long_x;
	logic                    old_ge_short;
	logic                    old_ge_long;
	logic                    new_ge_long;
	logic                    hit;
	event_code_t             ev_code;
	token_t                  tok_q;

	assign cnt_bumped = (cnt_q == '1) ? cnt_q : cnt_q + CounterWidth'(1);
	assign cnt_press  = enabled ? cnt_bumped : cnt_q;

	assign old_x   = CmpW'(cnt_q);
	assign new_x   = CmpW'(cnt_press);
	assign short_x = CmpW'(short_ticks);
	assign long_x  = CmpW'(long_ticks);

	assign old_ge_short = old_x >= short_x;
	assign old_ge_long  = old_x >= long_x;
	assign new_ge_long  = new_x >= long_x;

	// Release checks use the count held before this tick; hold checks use the bumped one.
	always_comb begin
		hit     = 1'b0;
		ev_code = short_code;
		unique case (kind)
			KIND_MENU: begin
				if (pressed) begin
					hit     = new_ge_long;
					ev_code = long_code;
				end else begin
					hit = old_ge_short && !old_ge_long;
				end
			end
			KIND_ENTER: begin
				if (pressed) begin
					hit     = new_ge_long;
					ev_code = long_code;
				end else begin
					hit = old_ge_short;
				end
			end
			KIND_COMBO: begin
				hit = pressed && new_ge_long;
			end
			default: begin
				hit = !pressed && old_ge_short;
			end
		endcase
	end

	assign ev_valid = active && hit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load && active) begin
			cnt_q <= pressed ? cnt_press : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (load) begin
			tok_q.valid <= ev_valid || ld_none;
			tok_q.last  <= ld_last || ld_none;
			tok_q.code  <= ld_none ? EV_NONE : ev_code;
		end else if (advance) begin
			tok_q <= up_tok;
		end
	end

	assign tok = tok_q;

endmodule

### dv/keypad_press_classifier_unit_tb.sv
module keypad_press_classifier_unit_tb;

	localparam int CLK_HALF       = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int TIMEOUT_CYCLES = 6000000;
	localparam int SETTLE_CYCLES  = 30;
	localparam int NUM_KEYS       = 22;
	localparam int COMBO_COUNT    = NUM_KEYS;
	localparam int NO_LED         = -1;
	localparam int SOAK_TICKS     = 20;
	localparam int RANDOM_PHASES  = 9;
	localparam int KEYS_OFF_PHASE = RANDOM_PHASES - 1;
	localparam int MAX_REPORTS    = 10;

	localparam logic [23:0] ALL_SENSORS = 24'hFF_FFFF;
	localparam logic [kpc_pkg::CFG_ADDR_W-1:0] CFG_SPARE_LO = 3'd6;
	localparam logic [kpc_pkg::CFG_ADDR_W-1:0] CFG_SPARE_HI = 3'd7;

	// Idle modes of the stream sides.
	localparam int IDLE_NONE     = 0;
	localparam int IDLE_SENDER   = 1;
	localparam int IDLE_RECEIVER = 2;
	localparam int IDLE_BOTH     = 3;

	// Scan positions of the keys that the bench refers to by name.
	localparam int K_START  = 0;
	localparam int K_AA     = 2;
	localparam int K_AB     = 4;
	localparam int K_MENU   = 5;
	localparam int K_PUNCH  = 9;

	typedef enum logic [kpc_pkg::CODE_W-1:0] {
		EV_START      = 5'd0,
		EV_STOP       = 5'd1,
		EV_AA         = 5'd2,
		EV_SECRET     = 5'd3,
		EV_AB         = 5'd4,
		EV_COMBO      = 5'd5,
		EV_MENU_LONG  = 5'd6,
		EV_MENU       = 5'd7,
		EV_RESET      = 5'd8,
		EV_BELT       = 5'd9,
		EV_STEP       = 5'd10,
		EV_PUNCH      = 5'd11,
		EV_ESC        = 5'd12,
		EV_N0         = 5'd13,
		EV_ENTER_LONG = 5'd14,
		EV_ENTER      = 5'd15,
		EV_N1         = 5'd16,
		EV_N4         = 5'd17,
		EV_N7         = 5'd18,
		EV_N2         = 5'd19,
		EV_N5         = 5'd20,
		EV_N8         = 5'd21,
		EV_N3         = 5'd22,
		EV_N6         = 5'd23,
		EV_N9         = 5'd24
	} key_event_t;

	typedef struct packed {
		logic       door;
		logic [7:0] bank_two;
		logic [7:0] bank_one;
		logic [7:0] bank_zero;
	} scan_tick_t;

	typedef struct {
		kpc_pkg::event_code_t          code;
		logic                          last;
		logic [kpc_pkg::LED_W-1:0]     led;
		logic                          flag;
	} key_result_t;

	// Key layout in scan order; sensor bits count bank 0 bit 0 as bit 0.
	localparam int KEY_SENSOR [NUM_KEYS] = '{
		19, 20, 16, 18, 21, 17, 22, 8, 9, 23, 15,
		13, 10, 0, 2, 5, 14, 12, 11, 1, 3, 4
	};
	localparam int KEY_LED [NUM_KEYS] = '{
		2, 3, 0, NO_LED, 1, 4, 5, 6, 7, 8, 9,
		11, 10, 12, 15, 18, 13, 16, 19, 14, 17, 20
	};
	localparam kpc_pkg::slot_kind_t KEY_KIND [NUM_KEYS] = '{
		kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN,
		kpc_pkg::KIND_SECRET, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_MENU,
		kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN,
		kpc_pkg::KIND_PUNCH, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN,
		kpc_pkg::KIND_ENTER, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN,
		kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN,
		kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN, kpc_pkg::KIND_PLAIN,
		kpc_pkg::KIND_PLAIN
	};
	localparam key_event_t KEY_SHORT [NUM_KEYS] = '{
		EV_START, EV_STOP, EV_AA, EV_SECRET, EV_AB, EV_MENU, EV_RESET, EV_BELT,
		EV_STEP, EV_PUNCH, EV_ESC, EV_N0, EV_ENTER, EV_N1, EV_N4, EV_N7,
		EV_N2, EV_N5, EV_N8, EV_N3, EV_N6, EV_N9
	};

	logic                                clk       = 1'b0;
	logic                                arst_n    = 1'b0;
	logic                                cfg_we    = 1'b0;
	logic [kpc_pkg::CFG_ADDR_W-1:0]      cfg_addr  = '0;
	logic [kpc_pkg::CFG_DATA_W-1:0]      cfg_wdata = '0;
	logic                                s_tvalid  = 1'b0;
	logic                                s_tready;
	// sensor_bank_zero[7:0], sensor_bank_one[15:8], sensor_bank_two[23:16],
	// door_shut[24], zero fill above
	logic [kpc_pkg::IN_TDATA_W-1:0]      s_tdata   = '0;
	logic                                m_tvalid;
	logic                                m_tready  = 1'b0;
	// event_code[4:0], led_mask[25:5], some_key_pressed[26], zero fill above
	logic [kpc_pkg::OUT_TDATA_W-1:0]     m_tdata;
	logic                                m_tlast;

	// Predictor state and its copy of the registers.
	logic [kpc_pkg::COUNTER_WIDTH-1:0]   hold_count [NUM_KEYS+1];
	logic [kpc_pkg::LED_W-1:0]           led_state;
	logic                                any_press;
	logic [kpc_pkg::THRESH_W-1:0]        short_ticks;
	logic [kpc_pkg::THRESH_W-1:0]        long_ticks;
	logic [kpc_pkg::LED_W-1:0]           key_mask;
	logic                                led_hold;
	logic                                punch_block;
	logic                                keys_off;

	scan_tick_t   pending_ticks [$];
	key_result_t  expected_events [$];
	logic         tick_taken = 1'b0;
	int           idle_mode = IDLE_NONE;
	int           mismatch_count = 0;
	logic [23:0]  held_sensors = '0;

	keypad_press_classifier_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic void bump_count(int idx);
		if (hold_count[idx] != '1) hold_count[idx]++;
	endfunction

	// Runs one scan tick through the predictor and queues the results it causes.
	function automatic void classify_tick(scan_tick_t tick);
		logic [23:0] sensors;
		kpc_pkg::event_code_t codes [$];
		logic pressed;
		logic fire;
		int led;
		sensors = {tick.bank_two, tick.bank_one, tick.bank_zero};
		if (keys_off) begin
			if (tick.door) any_press = 1'b1;
		end else begin
			for (int k = 0; k < NUM_KEYS; k++) begin
				pressed = sensors[KEY_SENSOR[k]];
				led = KEY_LED[k];
				if (pressed) begin
					if (led == NO_LED || key_mask[led]) bump_count(k);
					if (led != NO_LED && !led_hold) led_state[led] = 1'b1;
					if ((KEY_KIND[k] == kpc_pkg::KIND_MENU ||
						KEY_KIND[k] == kpc_pkg::KIND_ENTER) &&
						hold_count[k] >= long_ticks)
						codes.push_back(KEY_KIND[k] == kpc_pkg::KIND_MENU ?
							EV_MENU_LONG : EV_ENTER_LONG);
				end else begin
					fire = hold_count[k] >= short_ticks;
					// A menu press that already went long gives no release event.
					if (KEY_KIND[k] == kpc_pkg::KIND_MENU && hold_count[k] >= long_ticks)
						fire = 1'b0;
					if (fire) codes.push_back(KEY_SHORT[k]);
					hold_count[k] = '0;
					if (led != NO_LED && !led_hold &&
						!(KEY_KIND[k] == kpc_pkg::KIND_PUNCH && punch_block))
						led_state[led] = 1'b0;
				end
				// The combo counter is evaluated right after AB in the scan.
				if (k == K_AB) begin
					if (sensors[KEY_SENSOR[K_AA]] && sensors[KEY_SENSOR[K_AB]]) begin
						bump_count(COMBO_COUNT);
						if (hold_count[COMBO_COUNT] >= long_ticks) codes.push_back(EV_COMBO);
					end else begin
						hold_count[COMBO_COUNT] = '0;
					end
				end
			end
		end
		if (codes.size() == 0) codes.push_back(kpc_pkg::EV_NONE);
		foreach (codes[i])
			expected_events.push_back('{codes[i], i == codes.size() - 1, led_state, any_press});
	endfunction

	function automatic logic [23:0] key_sensor_bit(int k);
		return 24'(1) << KEY_SENSOR[k];
	endfunction

	// Mostly keys held over several ticks, now and then noise or a full release.
	function automatic logic [23:0] next_scan();
		int pick;
		pick = $urandom_range(0, 19);
		if (pick == 0) begin
			held_sensors = 24'($urandom);
		end else if (pick == 1) begin
			held_sensors = '0;
		end else begin
			for (int b = 0; b < 24; b++)
				if ($urandom_range(0, 9) == 0) held_sensors[b] = ~held_sensors[b];
		end
		return held_sensors;
	endfunction

	function automatic logic side_idles(int own_mode);
		if (idle_mode == own_mode) return $urandom_range(0, 99) < 62;
		if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 9;
		return 1'b0;
	endfunction

	task automatic queue_tick(logic [23:0] sensors, logic door);
		pending_ticks.push_back(scan_tick_t'({door, sensors}));
	endtask

	task automatic wait_idle();
		while (pending_ticks.size() != 0 || s_tvalid || expected_events.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(logic [kpc_pkg::CFG_ADDR_W-1:0] addr,
		logic [kpc_pkg::CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (addr)
			kpc_pkg::CFG_SHORT_TICKS: short_ticks = data[kpc_pkg::THRESH_W-1:0];
			kpc_pkg::CFG_LONG_TICKS:  long_ticks  = data[kpc_pkg::THRESH_W-1:0];
			kpc_pkg::CFG_KEY_MASK:    key_mask    = data[kpc_pkg::LED_W-1:0];
			kpc_pkg::CFG_LED_HOLD:    led_hold    = data[0];
			kpc_pkg::CFG_PUNCH_BLOCK: punch_block = data[0];
			kpc_pkg::CFG_KEYS_OFF:    keys_off    = data[0];
			default: ;
		endcase
	endtask

	// Sender: a tick stays offered until it is taken.
	always @(negedge clk) begin
		if (arst_n) begin
			if (s_tvalid && !tick_taken) begin
			end else if (pending_ticks.size() != 0 && !side_idles(IDLE_SENDER)) begin
				s_tvalid <= 1'b1;
				s_tdata <= kpc_pkg::IN_TDATA_W'(pending_ticks[0]);
			end else begin
				s_tvalid <= 1'b0;
			end
			tick_taken = 1'b0;
		end
	end

	always @(negedge clk) begin
		if (arst_n) m_tready <= !side_idles(IDLE_RECEIVER);
	end

	always @(posedge clk) begin
		key_result_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				classify_tick(scan_tick_t'(s_tdata[24:0]));
				void'(pending_ticks.pop_front());
				tick_taken = 1'b1;
			end
			if (m_tvalid && m_tready) begin
				if (expected_events.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: result with nothing expected: code %0d last %0b",
							$realtime, m_tdata[4:0], m_tlast);
				end else begin
					want = expected_events.pop_front();
					if (m_tdata[4:0] !== want.code || m_tlast !== want.last ||
						m_tdata[25:5] !== want.led || m_tdata[26] !== want.flag) begin
						mismatch_count++;
						if (mismatch_count <= MAX_REPORTS)
							$display("%0t: expected code %0d last %0b led %h flag %0b, got %s",
								$realtime, want.code, want.last, want.led, want.flag,
								$sformatf("code %0d last %0b led %h flag %0b",
									m_tdata[4:0], m_tlast, m_tdata[25:5], m_tdata[26]));
					end
				end
			end
		end
	end

	initial begin
		#(CLK_HALF * 2 * TIMEOUT_CYCLES);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		int items;
		short_ticks = kpc_pkg::SHORT_TICKS_RESET;
		long_ticks = kpc_pkg::LONG_TICKS_RESET;
		key_mask = '1;
		led_hold = 1'b0;
		punch_block = 1'b0;
		keys_off = 1'b0;
		led_state = '0;
		any_press = 1'b0;
		foreach (hold_count[i]) hold_count[i] = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset thresholds: a full press and release, then a press too short to count.
		idle_mode = IDLE_NONE;
		queue_tick('0, 1'b0);
		repeat (4) queue_tick(ALL_SENSORS, 1'b1);
		queue_tick('0, 1'b0);
		queue_tick(key_sensor_bit(K_START), 1'b0);
		queue_tick('0, 1'b0);
		wait_idle();

		// Zero thresholds with the key mask cleared, so long events fire at count zero.
		write_reg(kpc_pkg::CFG_SHORT_TICKS, '0);
		write_reg(kpc_pkg::CFG_LONG_TICKS, '0);
		write_reg(kpc_pkg::CFG_KEY_MASK, '0);
		queue_tick('0, 1'b1);
		queue_tick(ALL_SENSORS, 1'b0);
		queue_tick('0, 1'b0);
		wait_idle();

		// Menu held past the long threshold, punch LED kept lit after release.
		write_reg(kpc_pkg::CFG_SHORT_TICKS, 21'd2);
		write_reg(kpc_pkg::CFG_LONG_TICKS, 21'd4);
		write_reg(kpc_pkg::CFG_KEY_MASK, '1);
		write_reg(kpc_pkg::CFG_PUNCH_BLOCK, 21'd1);
		repeat (4) queue_tick(key_sensor_bit(K_PUNCH) | key_sensor_bit(K_MENU), 1'b0);
		queue_tick('0, 1'b0);
		wait_idle();

		write_reg(kpc_pkg::CFG_PUNCH_BLOCK, '0);
		write_reg(kpc_pkg::CFG_LED_HOLD, 21'd1);
		queue_tick(ALL_SENSORS, 1'b0);
		queue_tick('0, 1'b0);
		wait_idle();

		// Keys disabled: only a closed door matters, and the flag stays set.
		write_reg(kpc_pkg::CFG_LED_HOLD, '0);
		write_reg(kpc_pkg::CFG_KEYS_OFF, 21'd1);
		queue_tick(ALL_SENSORS, 1'b0);
		queue_tick(ALL_SENSORS, 1'b1);
		wait_idle();
		write_reg(kpc_pkg::CFG_KEYS_OFF, '0);
		queue_tick('0, 1'b0);
		wait_idle();

		// Hold every key for a while under the largest thresholds, then release.
		write_reg(kpc_pkg::CFG_SHORT_TICKS, {5'($urandom), 16'hFFFF});
		write_reg(kpc_pkg::CFG_LONG_TICKS, {5'($urandom), 16'hFFFF});
		for (int n = 0; n < SOAK_TICKS; n++) queue_tick(ALL_SENSORS, 1'($urandom));
		queue_tick('0, 1'b0);
		wait_idle();

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			idle_mode = phase % 4;
			write_reg(kpc_pkg::CFG_SHORT_TICKS, {5'($urandom),
				16'($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6))});
			write_reg(kpc_pkg::CFG_LONG_TICKS, {5'($urandom),
				16'($urandom_range(0, 4) == 0 ? 0 : $urandom_range(2, 14))});
			write_reg(kpc_pkg::CFG_KEY_MASK,
				$urandom_range(0, 2) == 0 ? 21'($urandom) : '1);
			write_reg(kpc_pkg::CFG_LED_HOLD, {20'($urandom), 1'($urandom_range(0, 4) == 0)});
			write_reg(kpc_pkg::CFG_PUNCH_BLOCK, {20'($urandom), 1'($urandom)});
			write_reg(kpc_pkg::CFG_KEYS_OFF, {20'($urandom), 1'(phase == KEYS_OFF_PHASE)});
			write_reg(phase[0] ? CFG_SPARE_LO : CFG_SPARE_HI, 21'($urandom));
			items = (phase == KEYS_OFF_PHASE) ? 15 : 56;
			for (int n = 0; n < items; n++) queue_tick(next_scan(), 1'($urandom));
			wait_idle();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		mismatch_count += expected_events.size();
		if (mismatch_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+rtl
rtl/kpc_pkg.sv
rtl/kpc_cell.sv
rtl/keypad_press_classifier_unit.sv
dv/keypad_press_classifier_unit_tb.sv
